[hdl/qrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants, count codes and word types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

   // field widths
   localparam int COEF_W = 16;
   localparam int EPS_W  = 16;
   localparam int CNT_W  = 2;
   localparam int ROOT_W = 32;

   // root count codes
   localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
   localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
   localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;
   localparam logic [CNT_W-1:0] CNT_ALL  = 2'd3;

   // discriminant, base term and divisor widths
   localparam int PROD_W = 2 * COEF_W;
   localparam int DISC_W = PROD_W + 3;
   localparam int RAD_W  = DISC_W - 2;
   localparam int BASE_W = COEF_W + 9;
   localparam int DEN_W  = COEF_W + 1;

   // square root unit: radicand is disc << 16, padded to an even width
   localparam int SQ_IN_W   = RAD_W + 17;
   localparam int SQ_STAGES = SQ_IN_W / 2;
   localparam int SQ_Q_W    = SQ_STAGES;
   localparam int SQ_R_W    = SQ_Q_W + 2;

   // divider: rounded dividend, one quotient bit per stage
   localparam int SUM_W  = SQ_Q_W + 2;
   localparam int MAG_W  = SUM_W - 1;
   localparam int NUM_W  = MAG_W + 9;
   localparam int SVAL_W = NUM_W + 1;

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // classified word handed from front to back
   typedef struct packed {
      logic [CNT_W-1:0]         count;
      logic [RAD_W-1:0]         rad;
      logic signed [BASE_W-1:0] base;
      logic [DEN_W-1:0]         den_mag;
      logic                     den_neg;
   } job_type;

   // side data carried along the divider stages
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             neg_p;
      logic             neg_m;
   } side_type;

endpackage

[hdl/qrs_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_fifo
// Short word queue between the classifying front and the solving back.
// ----------------------------------------------------------------------------
module qrs_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qrs_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output qrs_pkg::job_type  head_job
);

   qrs_pkg::job_type                   mem_ff [qrs_pkg::FIFO_DEPTH];
   logic [qrs_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff;
   logic [qrs_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff;
   logic [qrs_pkg::FIFO_CNT_W-1:0]     cnt_ff;
   logic [qrs_pkg::FIFO_CNT_W-1:0]     cnt_in;

   assign full     = (cnt_ff == qrs_pkg::FIFO_CNT_W'(qrs_pkg::FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (!push && pop) cnt_in = cnt_ff - 1'b1;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

[hdl/qrs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_front
// Takes coefficient words, forms the discriminant and classifies the case.
// ----------------------------------------------------------------------------
module qrs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [qrs_pkg::EPS_W-1:0]           eps,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_c,
   input  logic                                fifo_full,
   output logic                                push,
   output qrs_pkg::job_type                    job
);

   localparam int CW = qrs_pkg::COEF_W;

   logic                                  p_valid_ff;
   logic signed [CW-1:0]                  a_ff, b_ff, c_ff;
   logic signed [qrs_pkg::PROD_W-1:0]     bb_ff, ac_ff;
   logic signed [qrs_pkg::PROD_W-1:0]     bb_in, ac_in;
   logic                                  adv;

   logic [CW:0]                           a_mag, b_mag;
   logic                                  a_near, b_near, c_near;
   logic signed [qrs_pkg::DISC_W-1:0]     disc;
   logic                                  d_near;
   logic signed [qrs_pkg::BASE_W-1:0]     base_b, base_c;

   function automatic logic [CW:0] mag(input logic signed [CW-1:0] v);
      return v[CW-1] ? ((CW+1)'(0) - {1'b1, v}) : {1'b0, v};
   endfunction

   // v scaled to Q16.16 counts as zero when exactly zero or below eps
   function automatic logic near(input logic signed [CW-1:0] v,
                                 input logic [qrs_pkg::EPS_W-1:0] e);
      logic [CW+8:0] m;
      m = {mag(v), 8'b0};
      return (v == '0) || (m < (CW+9)'(e));
   endfunction

   assign adv       = !p_valid_ff || !fifo_full;
   assign req_stall = !adv;
   assign push      = p_valid_ff && !fifo_full;

   assign bb_in = req_coef_b * req_coef_b;
   assign ac_in = req_coef_a * req_coef_c;

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && req_valid) begin
         a_ff  <= req_coef_a;
         b_ff  <= req_coef_b;
         c_ff  <= req_coef_c;
         bb_ff <= bb_in;
         ac_ff <= ac_in;
      end
   end

   // discriminant and zero tests
   assign a_mag  = mag(a_ff);
   assign b_mag  = mag(b_ff);
   assign a_near = near(a_ff, eps);
   assign b_near = near(b_ff, eps);
   assign c_near = near(c_ff, eps);
   assign disc   = {{3{bb_ff[qrs_pkg::PROD_W-1]}}, bb_ff}
                 - ({{3{ac_ff[qrs_pkg::PROD_W-1]}}, ac_ff} <<< 2);
   assign d_near = (disc == '0) || (disc[qrs_pkg::DISC_W-2:0] < (qrs_pkg::DISC_W-1)'(eps));
   assign base_b = qrs_pkg::BASE_W'(0) - ({{9{b_ff[CW-1]}}, b_ff} <<< 8);
   assign base_c = qrs_pkg::BASE_W'(0) - ({{9{c_ff[CW-1]}}, c_ff} <<< 8);

   // case selection
   always_comb begin
      job.count   = qrs_pkg::CNT_NONE;
      job.rad     = '0;
      job.base    = base_b;
      job.den_mag = {a_mag[CW-1:0], 1'b0};
      job.den_neg = a_ff[CW-1];
      if (!a_near) begin
         if (disc[qrs_pkg::DISC_W-1]) begin
            job.count = qrs_pkg::CNT_NONE;
         end else if (d_near) begin
            job.count = qrs_pkg::CNT_ONE;
         end else begin
            job.count = qrs_pkg::CNT_TWO;
            job.rad   = disc[qrs_pkg::RAD_W-1:0];
         end
      end else if (!b_near) begin
         job.count   = qrs_pkg::CNT_ONE;
         job.base    = base_c;
         job.den_mag = b_mag;
         job.den_neg = b_ff[CW-1];
      end else if (c_near) begin
         job.count = qrs_pkg::CNT_ALL;
      end
   end

endmodule

[hdl/qrs_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root of disc << 16, one root bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  qrs_pkg::job_type                in_job,
   output logic                            out_valid,
   output qrs_pkg::job_type                out_job,
   output logic [qrs_pkg::SQ_Q_W-1:0]      out_root
);

   localparam int N  = qrs_pkg::SQ_STAGES;
   localparam int IW = qrs_pkg::SQ_IN_W;
   localparam int QW = qrs_pkg::SQ_Q_W;
   localparam int RW = qrs_pkg::SQ_R_W;

   logic                valid_ff [N];
   qrs_pkg::job_type    job_ff   [N];
   logic [IW-1:0]       rad_ff   [N];
   logic [RW-1:0]       rem_ff   [N];
   logic [QW-1:0]       root_ff  [N];

   logic [IW-1:0]       rad_src  [N];
   logic [RW-1:0]       rem_src  [N];
   logic [QW-1:0]       root_src [N];
   logic [RW+1:0]       rsh      [N];
   logic [RW-1:0]       trial    [N];
   logic                ge       [N];
   logic [IW-1:0]       rad_in   [N];
   logic [RW-1:0]       rem_in   [N];
   logic [QW-1:0]       root_in  [N];

   // one restoring step per stage
   always_comb begin
      rad_src[0]  = {1'b0, in_job.rad, 16'b0};
      rem_src[0]  = '0;
      root_src[0] = '0;
      for (int k = 1; k < N; k++) begin
         rad_src[k]  = rad_ff[k-1];
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
      end
      for (int k = 0; k < N; k++) begin
         rsh[k]     = {rem_src[k], rad_src[k][IW-1 -: 2]};
         trial[k]   = {root_src[k], 2'b01};
         ge[k]      = rsh[k] >= {2'b00, trial[k]};
         rem_in[k]  = ge[k] ? RW'(rsh[k] - {2'b00, trial[k]}) : RW'(rsh[k]);
         root_in[k] = {root_src[k][QW-2:0], ge[k]};
         rad_in[k]  = {rad_src[k][IW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < N; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         job_ff[0] <= in_job;
         for (int k = 1; k < N; k++) job_ff[k] <= job_ff[k-1];
         for (int k = 0; k < N; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_job   = job_ff[N-1];
   assign out_root  = root_ff[N-1];

endmodule

[hdl/qrs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [qrs_pkg::NUM_W-1:0]     in_num,
   input  logic [qrs_pkg::DEN_W-1:0]     in_den,
   output logic [qrs_pkg::NUM_W-1:0]     out_quo
);

   localparam int N  = qrs_pkg::NUM_W;
   localparam int DW = qrs_pkg::DEN_W;

   logic [N-1:0]  num_ff  [N];
   logic [DW-1:0] rem_ff  [N];
   logic [DW-1:0] den_ff  [N];

   logic [N-1:0]  num_src [N];
   logic [DW-1:0] rem_src [N];
   logic [DW-1:0] den_src [N];
   logic [DW:0]   rsh     [N];
   logic          ge      [N];
   logic [N-1:0]  num_in  [N];
   logic [DW-1:0] rem_in  [N];

   // dividend shifts out at the top, quotient bits shift in at the bottom
   always_comb begin
      num_src[0] = in_num;
      rem_src[0] = '0;
      den_src[0] = in_den;
      for (int k = 1; k < N; k++) begin
         num_src[k] = num_ff[k-1];
         rem_src[k] = rem_ff[k-1];
         den_src[k] = den_ff[k-1];
      end
      for (int k = 0; k < N; k++) begin
         rsh[k]    = {rem_src[k], num_src[k][N-1]};
         ge[k]     = rsh[k] >= {1'b0, den_src[k]};
         rem_in[k] = ge[k] ? DW'(rsh[k] - {1'b0, den_src[k]}) : DW'(rsh[k]);
         num_in[k] = {num_src[k][N-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            num_ff[k] <= num_in[k];
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_src[k];
         end
      end
   end

   assign out_quo = num_ff[N-1];

endmodule

[hdl/qrs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_back
// Square root, two rounded divisions, saturation, ordering and snapping.
// ----------------------------------------------------------------------------
module qrs_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [qrs_pkg::EPS_W-1:0]           eps,
   input  logic                                fifo_empty,
   input  qrs_pkg::job_type                    fifo_job,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [qrs_pkg::CNT_W-1:0]           rsp_root_count,
   output logic signed [qrs_pkg::ROOT_W-1:0]   rsp_root_low,
   output logic signed [qrs_pkg::ROOT_W-1:0]   rsp_root_high,
   output logic                                rsp_low_valid,
   output logic                                rsp_high_valid,
   output logic                                rsp_saturated
);

   localparam int RW = qrs_pkg::ROOT_W;
   localparam int SW = qrs_pkg::SUM_W;
   localparam int NW = qrs_pkg::NUM_W;
   localparam int VW = qrs_pkg::SVAL_W;

   logic en;

   // square root stage outputs
   logic                            sq_valid;
   qrs_pkg::job_type                sq_job;
   logic [qrs_pkg::SQ_Q_W-1:0]      sq_root;

   // numerator stage
   logic                            sum_valid_ff;
   qrs_pkg::side_type               sum_side_ff;
   logic [NW-1:0]                   num_p_ff, num_m_ff;
   logic [qrs_pkg::DEN_W-1:0]       den_ff;
   logic signed [SW-1:0]            base_ext, root_ext, sum_p, sum_m;
   logic [SW-1:0]                   abs_p, abs_m;
   qrs_pkg::side_type               side_in;
   logic [NW-1:0]                   num_p_in, num_m_in;

   // divider side pipe
   logic                            dv_valid_ff [NW];
   qrs_pkg::side_type               dv_side_ff  [NW];
   logic [NW-1:0]                   quo_p, quo_m;

   // signed and clamped roots
   logic                            f_valid_ff;
   logic [qrs_pkg::CNT_W-1:0]       f_count_ff;
   logic signed [RW-1:0]            r_p_ff, r_m_ff;
   logic                            s_p_ff, s_m_ff;
   logic [VW-1:0]                   v_p, v_m;

   // result register
   logic                            out_valid_ff;
   logic [qrs_pkg::CNT_W-1:0]       count_ff;
   logic signed [RW-1:0]            low_ff, high_ff;
   logic                            lv_ff, hv_ff, sat_ff;
   logic signed [RW-1:0]            lo_r, hi_r, low_in, high_in;
   logic                            lv_in, hv_in, sat_in;

   function automatic logic [VW-1:0] signed_val(input logic [NW-1:0] q, input logic neg);
      return neg ? (VW'(0) - {1'b0, q}) : {1'b0, q};
   endfunction

   function automatic logic over(input logic [VW-1:0] v);
      return v[VW-1] ? !(&v[VW-2:RW-1]) : (|v[VW-2:RW-1]);
   endfunction

   function automatic logic [RW-1:0] clamp(input logic [VW-1:0] v);
      logic [RW-1:0] r;
      r = v[RW-1:0];
      if (over(v)) r = v[VW-1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
      return r;
   endfunction

   function automatic logic signed [RW-1:0] snap(input logic signed [RW-1:0] r,
                                                 input logic [qrs_pkg::EPS_W-1:0] e);
      logic [RW-1:0] m;
      m = r[RW-1] ? (RW'(0) - r) : r;
      return (m < RW'(e)) ? '0 : r;
   endfunction

   // whole back advances together when the result register can take a word
   assign en  = !out_valid_ff || !rsp_stall;
   assign pop = en && !fifo_empty;

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (!fifo_empty),
      .in_job    (fifo_job),
      .out_valid (sq_valid),
      .out_job   (sq_job),
      .out_root  (sq_root)
   );

   // numerators (-x*256 +/- root) * 256 plus half divisor for rounding
   assign base_ext = {{(SW-qrs_pkg::BASE_W){sq_job.base[qrs_pkg::BASE_W-1]}}, sq_job.base};
   assign root_ext = {2'b00, sq_root};
   assign sum_p    = base_ext + root_ext;
   assign sum_m    = base_ext - root_ext;
   assign abs_p    = sum_p[SW-1] ? (SW'(0) - sum_p) : sum_p;
   assign abs_m    = sum_m[SW-1] ? (SW'(0) - sum_m) : sum_m;
   assign num_p_in = NW'({abs_p[qrs_pkg::MAG_W-1:0], 8'b0}) + NW'(sq_job.den_mag[qrs_pkg::DEN_W-1:1]);
   assign num_m_in = NW'({abs_m[qrs_pkg::MAG_W-1:0], 8'b0}) + NW'(sq_job.den_mag[qrs_pkg::DEN_W-1:1]);

   always_comb begin
      side_in.count = sq_job.count;
      side_in.neg_p = sum_p[SW-1] ^ sq_job.den_neg;
      side_in.neg_m = sum_m[SW-1] ^ sq_job.den_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (en) begin
         sum_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_side_ff <= side_in;
         num_p_ff    <= num_p_in;
         num_m_ff    <= num_m_in;
         den_ff      <= sq_job.den_mag;
      end
   end

   qrs_div u_div_p (
      .clock   (clock),
      .en      (en),
      .in_num  (num_p_ff),
      .in_den  (den_ff),
      .out_quo (quo_p)
   );

   qrs_div u_div_m (
      .clock   (clock),
      .en      (en),
      .in_num  (num_m_ff),
      .in_den  (den_ff),
      .out_quo (quo_m)
   );

   // side data kept in step with the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NW; k++) dv_valid_ff[k] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= sum_valid_ff;
         for (int k = 1; k < NW; k++) dv_valid_ff[k] <= dv_valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_side_ff[0] <= sum_side_ff;
         for (int k = 1; k < NW; k++) dv_side_ff[k] <= dv_side_ff[k-1];
      end
   end

   // sign and saturate
   assign v_p = signed_val(quo_p, dv_side_ff[NW-1].neg_p);
   assign v_m = signed_val(quo_m, dv_side_ff[NW-1].neg_m);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= dv_valid_ff[NW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_count_ff <= dv_side_ff[NW-1].count;
         r_p_ff     <= clamp(v_p);
         r_m_ff     <= clamp(v_m);
         s_p_ff     <= over(v_p);
         s_m_ff     <= over(v_m);
      end
   end

   // order, snap and drop unused roots
   assign lo_r = (r_p_ff > r_m_ff) ? r_m_ff : r_p_ff;
   assign hi_r = (r_p_ff > r_m_ff) ? r_p_ff : r_m_ff;

   always_comb begin
      low_in  = '0;
      high_in = '0;
      lv_in   = 1'b0;
      hv_in   = 1'b0;
      sat_in  = 1'b0;
      case (f_count_ff)
         qrs_pkg::CNT_ONE: begin
            low_in = snap(r_p_ff, eps);
            lv_in  = 1'b1;
            sat_in = s_p_ff;
         end
         qrs_pkg::CNT_TWO: begin
            low_in  = snap(lo_r, eps);
            high_in = snap(hi_r, eps);
            lv_in   = 1'b1;
            hv_in   = 1'b1;
            sat_in  = s_p_ff | s_m_ff;
         end
         default: begin
            low_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         count_ff <= f_count_ff;
         low_ff   <= low_in;
         high_ff  <= high_in;
         lv_ff    <= lv_in;
         hv_ff    <= hv_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_root_count = count_ff;
   assign rsp_root_low   = low_ff;
   assign rsp_root_high  = high_ff;
   assign rsp_low_valid  = lv_ff;
   assign rsp_high_valid = hv_ff;
   assign rsp_saturated  = sat_ff;

endmodule

[hdl/quadratic_root_solver_core.sv]
`timescale 1ns / 1ps
// throughput: one word per cycle while the receiver does not stall; the square root
//   (25 stages) and the two dividers (35 stages each) are fully pipelined, one bit per stage
// a 4-word queue separates the classifying front from the solving back
// reset is synchronous and active high; it empties the pipe and sets the zero tolerance to 1
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Real roots of a*x^2 + b*x + c = 0, Q8.8 coefficients in, Q16.16 roots out.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [qrs_pkg::EPS_W-1:0]           csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_c,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [qrs_pkg::CNT_W-1:0]           rsp_root_count,
   output logic signed [qrs_pkg::ROOT_W-1:0]   rsp_root_low,
   output logic signed [qrs_pkg::ROOT_W-1:0]   rsp_root_high,
   output logic                                rsp_low_valid,
   output logic                                rsp_high_valid,
   output logic                                rsp_saturated
);

   logic [qrs_pkg::EPS_W-1:0]  eps_ff;
   logic                       push, pop, full, empty;
   qrs_pkg::job_type           push_job, head_job;

   // zero tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= qrs_pkg::EPS_W'(1);
      end else if (csr_write_enable) begin
         eps_ff <= csr_write_data;
      end
   end

   qrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .eps        (eps_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_coef_a (req_coef_a),
      .req_coef_b (req_coef_b),
      .req_coef_c (req_coef_c),
      .fifo_full  (full),
      .push       (push),
      .job        (push_job)
   );

   qrs_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head_job (head_job)
   );

   qrs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .eps            (eps_ff),
      .fifo_empty     (empty),
      .fifo_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_root_count (rsp_root_count),
      .rsp_root_low   (rsp_root_low),
      .rsp_root_high  (rsp_root_high),
      .rsp_low_valid  (rsp_low_valid),
      .rsp_high_valid (rsp_high_valid),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

[hdl/qrs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the result words of the quadratic root solver.
// ----------------------------------------------------------------------------
module qrs_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [qrs_pkg::EPS_W-1:0]           csr_write_data,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_c,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [qrs_pkg::CNT_W-1:0]           rsp_root_count,
   input  logic signed [qrs_pkg::ROOT_W-1:0]   rsp_root_low,
   input  logic signed [qrs_pkg::ROOT_W-1:0]   rsp_root_high,
   input  logic                                rsp_low_valid,
   input  logic                                rsp_high_valid,
   input  logic                                rsp_saturated
);

   // no result word right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root_low)
         && $stable(rsp_root_high) && $stable(rsp_root_count))
      else $error("stalled result word changed");

   // valid bits follow the root count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_low_valid == (rsp_root_count == qrs_pkg::CNT_ONE
                                    || rsp_root_count == qrs_pkg::CNT_TWO))
                 && (rsp_high_valid == (rsp_root_count == qrs_pkg::CNT_TWO)))
      else $error("root valid bits disagree with root count");

   // two roots come out in ascending order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_high_valid |-> rsp_root_low <= rsp_root_high)
      else $error("roots out of order");

   // no root means zero fields and no saturation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_low_valid |-> rsp_root_low == '0 && rsp_root_high == '0
                                      && !rsp_saturated)
      else $error("unused root fields not cleared");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (.*);

[bench/quadratic_root_solver_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_core_tb
// Drives coefficient words through the solver with random idling on both
// sides and checks each result word against a built-in root predictor or a typed row.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core_tb;

   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_WORDS = 600;

   typedef struct packed {
      logic [qrs_pkg::CNT_W-1:0]  count;
      logic [qrs_pkg::ROOT_W-1:0] lo;
      logic [qrs_pkg::ROOT_W-1:0] hi;
      logic                       lv;
      logic                       hv;
      logic                       sat;
   } roots_type;

   typedef struct {
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] c;
      bit          typed;
      roots_type   want;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [qrs_pkg::EPS_W-1:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [qrs_pkg::COEF_W-1:0] req_coef_a = '0;
   logic signed [qrs_pkg::COEF_W-1:0] req_coef_b = '0;
   logic signed [qrs_pkg::COEF_W-1:0] req_coef_c = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [qrs_pkg::CNT_W-1:0] rsp_root_count;
   logic signed [qrs_pkg::ROOT_W-1:0] rsp_root_low;
   logic signed [qrs_pkg::ROOT_W-1:0] rsp_root_high;
   logic rsp_low_valid;
   logic rsp_high_valid;
   logic rsp_saturated;

   quadratic_root_solver_core DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coef_a(req_coef_a), .req_coef_b(req_coef_b), .req_coef_c(req_coef_c),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_root_count(rsp_root_count), .rsp_root_low(rsp_root_low),
      .rsp_root_high(rsp_root_high), .rsp_low_valid(rsp_low_valid),
      .rsp_high_valid(rsp_high_valid), .rsp_saturated(rsp_saturated)
   );

   // predictor copy of the tolerance register
   logic [qrs_pkg::EPS_W-1:0] eps_q = 16'd1;
   roots_type pending_roots[$];
   int failures = 0;
   int idle_cycles = 0;
   bit rx_calm = 0;
   bit hold_rx = 0;

   // typed expectation, driven together with the word it belongs to
   bit row_typed = 0;
   roots_type row_want = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic bit is_tiny(longint v);
      return v == 0 || mag(v) < longint'(eps_q);
   endfunction

   // rounded quotient, ties away from zero
   function automatic longint round_div(longint num, longint den);
      longint q;
      q = (mag(num) + mag(den) / 2) / mag(den);
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   function automatic longint clamp32(longint v, ref logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint snap_zero(longint v);
      return mag(v) < longint'(eps_q) ? 0 : v;
   endfunction

   function automatic longint floor_sqrt(longint unsigned x);
      longint unsigned r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
         if (x >= r + bt) begin
            x -= r + bt;
            r = (r >> 1) + bt;
         end else begin
            r >>= 1;
         end
         bt >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic roots_type solve_roots(logic [15:0] ra, logic [15:0] rb,
                                             logic [15:0] rc);
      roots_type r;
      longint a, b, c, d, s, nb, r1, r2, t;
      logic sat;
      a = longint'($signed(ra));
      b = longint'($signed(rb));
      c = longint'($signed(rc));
      r = '0;
      sat = 0;
      if (!is_tiny(a * 256)) begin
         d = b * b - 4 * a * c;
         if (d < 0) begin
            r.count = qrs_pkg::CNT_NONE;
         end else if (is_tiny(d)) begin
            r1 = snap_zero(clamp32(round_div(-b * 65536, 2 * a), sat));
            r.count = qrs_pkg::CNT_ONE;
            r.lo = r1[31:0];
            r.lv = 1;
         end else begin
            s = floor_sqrt(longint'(d) << 16);
            nb = -b * 256;
            r1 = clamp32(round_div((nb + s) * 256, 2 * a), sat);
            r2 = clamp32(round_div((nb - s) * 256, 2 * a), sat);
            if (r1 > r2) begin
               t = r1;
               r1 = r2;
               r2 = t;
            end
            r1 = snap_zero(r1);
            r2 = snap_zero(r2);
            r.count = qrs_pkg::CNT_TWO;
            r.lo = r1[31:0];
            r.hi = r2[31:0];
            r.lv = 1;
            r.hv = 1;
         end
      end else if (!is_tiny(b * 256)) begin
         r1 = snap_zero(clamp32(round_div(-c * 65536, b), sat));
         r.count = qrs_pkg::CNT_ONE;
         r.lo = r1[31:0];
         r.lv = 1;
      end else if (is_tiny(c * 256)) begin
         r.count = qrs_pkg::CNT_ALL;
      end else begin
         r.count = qrs_pkg::CNT_NONE;
      end
      r.sat = sat;
      return r;
   endfunction

   // drive one coefficient word and wait for it to be taken
   task automatic send_word(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                            bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_eps(logic [15:0] v);
      req_valid <= 0;
      while (pending_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      eps_q = v;
   endtask

   // record the expectation at the accepting edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_roots.push_back(row_typed ? row_want
                                 : solve_roots(req_coef_a, req_coef_b, req_coef_c));
   end

   // check result words
   always @(posedge clock) begin
      roots_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_roots.size() == 0) begin
            $error("unexpected result word");
            failures++;
         end else begin
            want = pending_roots.pop_front();
            if (rsp_root_count !== want.count) begin
               $error("root_count expected %0d actual %0d", want.count, rsp_root_count);
               failures++;
            end
            if (rsp_root_low !== want.lo) begin
               $error("root_low expected %h actual %h", want.lo, rsp_root_low);
               failures++;
            end
            if (rsp_root_high !== want.hi) begin
               $error("root_high expected %h actual %h", want.hi, rsp_root_high);
               failures++;
            end
            if (rsp_low_valid !== want.lv) begin
               $error("low_valid expected %0b actual %0b", want.lv, rsp_low_valid);
               failures++;
            end
            if (rsp_high_valid !== want.hv) begin
               $error("high_valid expected %0b actual %0b", want.hv, rsp_high_valid);
               failures++;
            end
            if (rsp_saturated !== want.sat) begin
               $error("saturated expected %0b actual %0b", want.sat, rsp_saturated);
               failures++;
            end
         end
      end
   end

   // receiver stall: random bursts, a long hold-off on request, none when calm
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_rx) begin
            rsp_stall <= 1;
            n = 0;
            while (n < 300) begin
               @(posedge clock);
               n++;
            end
            rsp_stall <= 0;
            hold_rx = 0;
         end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // random coefficient: moderate half the time, else full range, near zero or zero
   function automatic logic [15:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 65535));
         1: return 16'($signed($urandom_range(0, 8)) - 4);
         2: return 16'($signed($urandom_range(0, 0)));
         default: return 16'($signed($urandom_range(0, 4096)) - 2048);
      endcase
   endfunction

   // directed stimulus; typed expectations hold for the reset tolerance
   row_type rows[$];
   row_type rw;
   logic [15:0] eps_set[4] = '{16'd0, 16'd65535, 16'd300, 16'd1};

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      rows = '{
         '{16'h0000, 16'h0000, 16'h0000, 1,
           '{qrs_pkg::CNT_ALL, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0}},
         '{16'h0000, 16'h0000, 16'h0100, 1,
           '{qrs_pkg::CNT_NONE, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0}},
         '{16'h0000, 16'h0100, 16'hFF00, 1,
           '{qrs_pkg::CNT_ONE, 32'h10000, 32'h0, 1'b1, 1'b0, 1'b0}},
         '{16'h0100, 16'h0000, 16'hFF00, 1,
           '{qrs_pkg::CNT_TWO, 32'hFFFF0000, 32'h10000, 1'b1, 1'b1, 1'b0}},
         '{16'h0100, 16'h0000, 16'h0100, 1,
           '{qrs_pkg::CNT_NONE, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0}},
         '{16'h0100, 16'hFE00, 16'h0100, 1,
           '{qrs_pkg::CNT_ONE, 32'h10000, 32'h0, 1'b1, 1'b0, 1'b0}},
         '{16'h0000, 16'h0001, 16'h7FFF, 1,
           '{qrs_pkg::CNT_ONE, 32'h80010000, 32'h0, 1'b1, 1'b0, 1'b0}},
         '{16'h0001, 16'h7FFF, 16'h0000, 0, '0},
         '{16'h8000, 16'h8000, 16'h8000, 0, '0},
         '{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0},
         '{16'h7FFF, 16'h8000, 16'h8000, 0, '0},
         '{16'h8000, 16'h7FFF, 16'h7FFF, 0, '0},
         '{16'h0001, 16'h0000, 16'h8000, 0, '0},
         '{16'hFFFF, 16'h0001, 16'h7FFF, 0, '0},
         '{16'h0000, 16'hFFFF, 16'h8000, 0, '0},
         '{16'h0000, 16'h8000, 16'h0001, 0, '0},
         '{16'h5555, 16'hAAAA, 16'h5555, 0, '0},
         '{16'hAAAA, 16'h5555, 16'hAAAA, 0, '0},
         '{16'h0200, 16'h0600, 16'h0400, 0, '0},
         '{16'hFF00, 16'h0100, 16'h0600, 0, '0}
      };

      // directed table, typed rows override the predictor
      foreach (rows[i]) begin
         rw = rows[i];
         row_typed <= rw.typed;
         row_want <= rw.want;
         send_word(rw.a, rw.b, rw.c, 0);
      end
      req_valid <= 0;
      row_typed <= 0;

      // random phases across tolerance settings
      foreach (eps_set[p]) begin
         write_eps(eps_set[p]);
         if (p == 1) hold_rx = 1;
         if (p == 3) rx_calm = 1;
         for (int k = 0; k < RANDOM_WORDS / 4; k++)
            send_word(pick_coef(), pick_coef(), pick_coef(), !rx_calm);
         req_valid <= 0;
      end

      while (pending_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
